[src/mtis_pkg.sv]
// Package: item types and constants for the missing-tooth ignition scheduler.
`timescale 1ns / 1ps
package mtis_pkg;

  localparam logic [1:0] CMD_TOOTH    = 2'd0;
  localparam logic [1:0] CMD_OVERFLOW = 2'd1;
  localparam logic [1:0] CMD_WRITE    = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_FIRE   = 2'd1;
  localparam logic [1:0] ACT_CHARGE = 2'd2;
  localparam logic [1:0] ACT_STALL  = 2'd3;

  localparam logic [15:0] STALL_LIMIT = 16'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] capture_count;
    logic [2:0]  entry_index;
    logic [5:0]  fire_tooth;
    logic [7:0]  fire_degrees;
    logic [5:0]  charge_tooth;
    logic [7:0]  charge_degrees;
    logic [7:0]  port_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  drive_mask;
    logic [31:0] delay_ticks;
    logic        synced;
    logic        running;
    logic        revolution_done;
    logic [31:0] revolution_period;
    logic [5:0]  tooth_number;
    logic [15:0] sync_failures;
  } out_item_t;

  typedef struct packed {
    logic [5:0] fire_tooth;
    logic [7:0] fire_degrees;
    logic [5:0] charge_tooth;
    logic [7:0] charge_degrees;
    logic [7:0] port_mask;
  } coil_entry_t;

endpackage

[src/missing_tooth_ignition_scheduler.sv]
// Top level: crank wheel decoder with memory-resident coil table and ignition scheduler.
`timescale 1ns / 1ps
// One item is handled at a time. An overflow, a table write, an unknown command
// or a tooth edge that leaves the wheel out of sync goes from acceptance
// straight to the output state. A tooth edge in sync first scans the N coil
// entries in use (N is driver_count, capped at MAX_COILS): the coil table is a
// synchronous memory, and the scheduler reads it one entry at a time, with the
// address presented in a read state and the data checked in a check state,
// first from last to first for a fire match, then, if none is found, from first
// to last for a charge match (both banks are read together at one address).
// The delay is computed in S_DIV, S_FIX, S_MUL and S_SUM: one constant multiply
// by the reciprocal of TOOTH_DEGREES with a correction, one 32x8 multiply, then
// add and shift. The result sits in an output register; the next item is taken
// once that register is empty or being drained. No clearing pass is needed.
module missing_tooth_ignition_scheduler #(
  parameter int WHEEL_TEETH   = 36,
  parameter int TOOTH_DEGREES = 10,
  parameter int MAX_COILS     = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mtis_pkg::in_item_t       in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output mtis_pkg::out_item_t      out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [3:0]               cfg_data
);

  localparam int IW = (MAX_COILS > 1) ? $clog2(MAX_COILS) : 1;
  localparam int CW = $clog2(MAX_COILS + 1);
  localparam logic [5:0] LAST_TOOTH = 6'(WHEEL_TEETH - 1);
  // reciprocal for p / TOOTH_DEGREES: floor(p*R >> 32) is at most one low
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(TOOTH_DEGREES));

  typedef enum logic [3:0] {
    S_IDLE, S_FIRE_RD, S_FIRE_CHK, S_CHG_RD, S_CHG_CHK,
    S_DIV, S_FIX, S_MUL, S_SUM, S_OUT
  } state_t;

  state_t state;
  logic [3:0] driver_count;

  // architectural state
  logic [5:0]  tooth_counter;
  logic [31:0] previous_tooth_period;
  logic [31:0] revolution_accumulator;
  logic [31:0] completed_revolution;
  logic [15:0] overflow_counter;
  logic        sync_flag, running_flag, active_bank;
  logic [15:0] failure_counter;

  // coil table: one row per entry index holds both banks
  mtis_pkg::coil_entry_t mem_b0 [MAX_COILS];
  mtis_pkg::coil_entry_t mem_b1 [MAX_COILS];
  mtis_pkg::coil_entry_t rd_b0, rd_b1;
  logic [IW-1:0] rd_addr;

  // per-item work registers
  logic [31:0] p;
  logic [5:0]  next_tooth;
  logic        swapped, prev_bank, rev_done;
  logic [CW-1:0] idx;
  logic [CW-1:0] n_use;
  logic [1:0]  action;
  logic [7:0]  mask;
  logic [7:0]  deg;
  logic        dbl;
  logic [64:0] quot_prod;
  logic [31:0] quot;
  logic [39:0] scaled;
  logic        out_full;

  wire accept = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE) || (out_full && out_stall);
  assign cfg_ready = (state == S_IDLE) && !out_full;
  assign out_valid = out_full;

  wire [IW-1:0] wr_idx = IW'(in_item.entry_index);
  wire wr_ok = (32'(in_item.entry_index) < 32'(MAX_COILS));
  wire mtis_pkg::coil_entry_t wr_entry = '{in_item.fire_tooth, in_item.fire_degrees,
      in_item.charge_tooth, in_item.charge_degrees, in_item.port_mask};

  // memory
  always_ff @(posedge clk) begin
    if (accept && in_item.command == mtis_pkg::CMD_WRITE && wr_ok) begin
      if (active_bank) mem_b0[wr_idx] <= wr_entry;
      else mem_b1[wr_idx] <= wr_entry;
    end
    rd_b0 <= mem_b0[rd_addr];
    rd_b1 <= mem_b1[rd_addr];
  end

  mtis_pkg::coil_entry_t cur_e, old_e;
  assign cur_e = active_bank ? rd_b1 : rd_b0;
  assign old_e = prev_bank ? rd_b1 : rd_b0;

  // tooth edge front end
  logic [31:0] cap_p;
  logic [32:0] limit;
  logic        gap;
  logic [32:0] acc_sum, rev_sum;
  logic [5:0]  tooth_new;
  logic [5:0]  nxt_raw;
  always_comb begin
    cap_p    = {overflow_counter, in_item.capture_count};
    limit    = 33'(previous_tooth_period) + 33'(previous_tooth_period >> 1);
    gap      = 33'(cap_p) > limit;
    acc_sum  = 33'(revolution_accumulator) + 33'(cap_p);
    rev_sum  = 33'(revolution_accumulator) + 33'(cap_p >> 1);
    tooth_new = gap ? 6'd1 : tooth_counter + 6'd1;
    nxt_raw  = tooth_new + 6'd1;
  end

  logic [IW-1:0] idx_m1;
  assign idx_m1 = IW'(idx - CW'(1));
  // address presented in the read state, data checked in the following one
  assign rd_addr = (state == S_FIRE_RD) ? idx_m1 : idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      driver_count <= 4'd1;
      tooth_counter <= '0;
      previous_tooth_period <= '0;
      revolution_accumulator <= '0;
      completed_revolution <= '0;
      overflow_counter <= '0;
      sync_flag <= 1'b0;
      running_flag <= 1'b0;
      active_bank <= 1'b0;
      failure_counter <= '0;
      out_full <= 1'b0;
    end else begin
      if (out_full && !out_stall) out_full <= 1'b0;
      if (cfg_valid && cfg_ready) driver_count <= cfg_data;
      case (state)
        S_IDLE: begin
          if (accept) begin
            action <= mtis_pkg::ACT_NONE;
            mask <= '0;
            dbl <= 1'b0;
            deg <= '0;
            rev_done <= 1'b0;
            swapped <= 1'b0;
            state <= S_OUT;
            n_use <= (32'(driver_count) > 32'(MAX_COILS)) ? CW'(MAX_COILS) : CW'(driver_count);
            case (in_item.command)
              mtis_pkg::CMD_OVERFLOW: begin
                if (overflow_counter != 16'hFFFF) begin
                  if (overflow_counter + 16'd1 > mtis_pkg::STALL_LIMIT) begin
                    action <= mtis_pkg::ACT_STALL;
                    mask <= 8'hFF;
                    running_flag <= 1'b0;
                  end
                  overflow_counter <= overflow_counter + 16'd1;
                end else begin
                  action <= mtis_pkg::ACT_STALL;
                  mask <= 8'hFF;
                  running_flag <= 1'b0;
                end
              end
              mtis_pkg::CMD_TOOTH: begin
                prev_bank <= active_bank;
                if (gap) begin
                  p <= cap_p >> 1;
                  previous_tooth_period <= cap_p >> 1;
                  revolution_accumulator <= cap_p >> 1;
                  if (tooth_counter != LAST_TOOTH) begin
                    sync_flag <= 1'b0;
                    if (failure_counter != 16'hFFFF) failure_counter <= failure_counter + 16'd1;
                  end else begin
                    sync_flag <= 1'b1;
                    completed_revolution <= rev_sum[32] ? 32'hFFFF_FFFF : rev_sum[31:0];
                    swapped <= 1'b1;
                    active_bank <= ~active_bank;
                    rev_done <= 1'b1;
                    running_flag <= 1'b1;
                  end
                end else begin
                  p <= cap_p;
                  previous_tooth_period <= cap_p;
                  revolution_accumulator <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                end
                tooth_counter <= tooth_new;
                next_tooth <= (32'(nxt_raw) >= WHEEL_TEETH || nxt_raw == 6'd0)
                              ? 6'd0 : nxt_raw;
                overflow_counter <= '0;
                idx <= (32'(driver_count) > 32'(MAX_COILS)) ? CW'(MAX_COILS)
                       : CW'(driver_count);
                if ((gap && tooth_counter == LAST_TOOTH) || (!gap && sync_flag))
                  state <= S_FIRE_RD;
              end
              default: ;
            endcase
          end
        end
        // fire pass: idx counts down, reading entry idx-1
        S_FIRE_RD: begin
          if (idx == '0) begin
            idx <= '0;
            state <= S_CHG_RD;
          end else begin
            state <= S_FIRE_CHK;
          end
        end
        S_FIRE_CHK: begin
          if (cur_e.fire_tooth == next_tooth) begin
            action <= mtis_pkg::ACT_FIRE;
            mask <= cur_e.port_mask;
            deg <= cur_e.fire_degrees;
            state <= S_DIV;
          end else begin
            idx <= idx - CW'(1);
            state <= S_FIRE_RD;
          end
        end
        S_CHG_RD: begin
          if (idx >= n_use) begin
            state <= S_OUT;
          end else begin
            state <= S_CHG_CHK;
          end
        end
        S_CHG_CHK: begin
          state <= S_DIV;
          action <= mtis_pkg::ACT_CHARGE;
          if (cur_e.charge_tooth == next_tooth) begin
            mask <= cur_e.port_mask;
            deg <= cur_e.charge_degrees;
          end else if (next_tooth == 6'd0 && cur_e.charge_tooth == 6'd1) begin
            mask <= cur_e.port_mask;
            deg <= cur_e.charge_degrees;
            dbl <= 1'b1;
          end else if (swapped && old_e.charge_tooth == next_tooth) begin
            mask <= old_e.port_mask;
            deg <= old_e.charge_degrees;
          end else begin
            action <= mtis_pkg::ACT_NONE;
            idx <= idx + CW'(1);
            state <= S_CHG_RD;
          end
        end
        S_DIV: begin
          quot_prod <= 65'(p) * 65'(RECIP);
          state <= S_FIX;
        end
        S_FIX: begin
          if (64'(p) - 64'(quot_prod[63:32]) * 64'(TOOTH_DEGREES) >= 64'(TOOTH_DEGREES))
            quot <= quot_prod[63:32] + 32'd1;
          else
            quot <= quot_prod[63:32];
          state <= S_MUL;
        end
        S_MUL: begin
          scaled <= 40'(quot) * 40'(deg);
          state <= S_SUM;
        end
        S_SUM: begin
          // sum of up to 2p + scaled fits in 42 bits
          begin : sum_blk
            logic [41:0] s;
            logic [39:0] q;
            s = (dbl ? {9'd0, p, 1'b0} : {10'd0, p}) + {2'd0, scaled};
            q = s[41:2];
            quot_prod <= {25'd0, (q > 40'hFF_FFFF_FFFF >> 8) ? 32'hFFFF_FFFF : q[31:0], 8'd0};
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_full <= 1'b1;
          out_item.action <= action;
          out_item.drive_mask <= mask;
          out_item.delay_ticks <= (action == mtis_pkg::ACT_FIRE || action == mtis_pkg::ACT_CHARGE)
                                  ? quot_prod[39:8] : 32'd0;
          out_item.synced <= sync_flag;
          out_item.running <= running_flag;
          out_item.revolution_done <= rev_done;
          out_item.revolution_period <= completed_revolution;
          out_item.tooth_number <= tooth_counter;
          out_item.sync_failures <= failure_counter;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (!out_full || !out_stall))
    else $error("result register overrun");
  // no item enters while the scheduler is busy
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("item accepted while busy");
  // a stall report always drives every pin
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.action == mtis_pkg::ACT_STALL) |-> out_item.drive_mask == 8'hFF)
    else $error("stall without full mask");

endmodule
